### design/ookt_pkg.sv
// Shared types and constants for the OOK pulse message transmitter.
`timescale 1ns / 1ps

package ookt_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_MSGSTART  = 3'd1,
    PH_BYTESTART = 3'd2,
    PH_SENDBYTE  = 3'd3,
    PH_MSGEND    = 3'd4,
    PH_GAPSTART  = 3'd5,
    PH_GAPEND    = 3'd6
  } phase_t;

  localparam logic [2:0] REG_TICK_COUNTS     = 3'd0;
  localparam logic [2:0] REG_GAP_MULTIPLIER  = 3'd1;
  localparam logic [2:0] REG_REPEAT_TOTAL    = 3'd2;
  localparam logic [2:0] REG_INVERT_LINE     = 3'd3;
  localparam logic [2:0] REG_TRANSLATE       = 3'd4;
  localparam logic [2:0] REG_CODE_TABLE_LOW  = 3'd5;
  localparam logic [2:0] REG_CODE_TABLE_HIGH = 3'd6;

  localparam logic [31:0] TICK_COUNTS_RESET  = 32'h0704_0248;
  localparam logic [5:0]  REPEAT_TOTAL_RESET = 6'd12;
  localparam logic [7:0]  BIT_SELECT_MSB     = 8'h80;

  typedef struct packed {
    logic [7:0] low_cnt;
    logic [7:0] high_cnt;
    logic [7:0] trail_cnt;
    logic [7:0] gap_cnt;
    logic [7:0] gap_multiplier;
    logic [5:0] repeat_total;
  } seq_cfg_t;

  typedef struct packed {
    logic active;
    logic line_state;
  } seq_status_t;

endpackage

### design/ookt_seq.sv
// Tick sequencer: countdown, transmit phases, bit selection and repeat count.
`timescale 1ns / 1ps

module ookt_seq #(
  parameter int MSG_LEN = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_en,
  input  logic                start_en,
  input  ookt_pkg::seq_cfg_t  cfg,
  input  logic [7:0]          store_rdata,
  output logic [3:0]          rd_index,
  output ookt_pkg::seq_status_t cur,
  output ookt_pkg::seq_status_t nxt
);
  import ookt_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] countdown, countdown_next;
  logic [3:0] current_byte, current_byte_next;
  logic [7:0] bit_select, bit_select_next;
  logic [5:0] repeat_done, repeat_done_next;
  logic [7:0] gaps_left, gaps_left_next;
  logic       active, active_next;
  logic       line_state, line_state_next;

  logic [7:0] cd_dec;
  logic [7:0] bs_shift;
  logic [4:0] byte_inc;
  logic [5:0] rep_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      countdown    <= '0;
      current_byte <= '0;
      bit_select   <= '0;
      repeat_done  <= '0;
      gaps_left    <= '0;
      active       <= 1'b0;
      line_state   <= 1'b0;
    end else begin
      phase        <= phase_next;
      countdown    <= countdown_next;
      current_byte <= current_byte_next;
      bit_select   <= bit_select_next;
      repeat_done  <= repeat_done_next;
      gaps_left    <= gaps_left_next;
      active       <= active_next;
      line_state   <= line_state_next;
    end
  end

  assign cd_dec   = countdown - 8'd1;
  assign bs_shift = bit_select >> 1;
  assign byte_inc = {1'b0, current_byte} + 5'd1;
  assign rep_inc  = repeat_done + 6'd1;

  always_comb begin
    phase_next        = phase;
    countdown_next    = countdown;
    current_byte_next = current_byte;
    bit_select_next   = bit_select;
    repeat_done_next  = repeat_done;
    gaps_left_next    = gaps_left;
    active_next       = active;
    line_state_next   = line_state;

    if (start_en) begin
      active_next = 1'b1;
    end else if (tick_en && active) begin
      countdown_next = cd_dec;
      if (cd_dec == cfg.trail_cnt) begin
        line_state_next = 1'b0;
      end else if (cd_dec == 8'd0) begin
        countdown_next = cfg.high_cnt;
        case (phase)
          PH_IDLE: begin
            repeat_done_next = '0;
            phase_next       = PH_MSGSTART;
          end
          PH_MSGSTART: begin
            line_state_next   = 1'b1;
            current_byte_next = '0;
            phase_next        = PH_BYTESTART;
          end
          PH_BYTESTART: begin
            line_state_next = 1'b1;
            bit_select_next = BIT_SELECT_MSB;
            phase_next      = PH_SENDBYTE;
          end
          PH_SENDBYTE: begin
            if ((store_rdata & bit_select) != 8'd0) begin
              line_state_next = 1'b1;
            end else begin
              countdown_next = cfg.low_cnt;
            end
            bit_select_next = bs_shift;
            if (bs_shift == 8'd0) begin
              current_byte_next = byte_inc[3:0];
              phase_next = (byte_inc >= 5'(MSG_LEN)) ? PH_MSGEND : PH_BYTESTART;
            end
          end
          PH_MSGEND: begin
            line_state_next = 1'b1;
            phase_next      = PH_GAPSTART;
            gaps_left_next  = cfg.gap_multiplier;
          end
          PH_GAPSTART: begin
            countdown_next = cfg.gap_cnt;
            if (gaps_left == 8'd0) begin
              phase_next = PH_GAPEND;
            end else begin
              gaps_left_next = gaps_left - 8'd1;
            end
          end
          PH_GAPEND: begin
            repeat_done_next = rep_inc;
            if (rep_inc >= cfg.repeat_total) begin
              active_next = 1'b0;
              phase_next  = PH_IDLE;
            end else begin
              phase_next = PH_MSGSTART;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign rd_index       = current_byte;
  assign cur.active     = active;
  assign cur.line_state = line_state;
  assign nxt.active     = active_next;
  assign nxt.line_state = line_state_next;

endmodule

### design/ook_pulse_message_transmitter.sv
// Top level: configuration registers, message store, sequencer and result register.
`timescale 1ns / 1ps

// Tick-driven on-off-keyed message transmitter. Each input transaction is a
// tick, a message byte write, a start or a no-op, and yields exactly one result
// transaction carrying the line level and busy flag after that command. One
// transaction is taken per clock cycle; its result appears in the output
// register on the next cycle. Input tready is high whenever the output register
// is empty or is being drained in the same cycle, so the rate is one per cycle
// while the downstream side keeps tready high. Configuration writes are applied
// at once; the line inversion register acts on results produced after it.

module ook_pulse_message_transmitter #(
  parameter int MSG_LEN = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // byte_index[3:0], byte_value[11:4]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // line_level[0], busy_res[1]
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ookt_pkg::*;

  localparam int IDX_W = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;

  logic [31:0] tick_counts;
  logic [7:0]  gap_multiplier;
  logic [5:0]  repeat_total;
  logic        invert_line;
  logic        translate_enable;
  logic [63:0] code_table_low;
  logic [63:0] code_table_high;

  logic [7:0] message_store [MSG_LEN];

  logic       in_accept;
  cmd_t       cmd;
  logic [3:0] byte_index;
  logic [7:0] byte_value;
  logic [63:0] code_sel;
  logic [7:0] write_byte;
  logic [3:0] rd_index;
  logic [7:0] store_rdata;

  seq_cfg_t    seq_cfg;
  seq_status_t seq_cur;
  seq_status_t seq_nxt;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counts      <= TICK_COUNTS_RESET;
      gap_multiplier   <= '0;
      repeat_total     <= REPEAT_TOTAL_RESET;
      invert_line      <= 1'b0;
      translate_enable <= 1'b0;
      code_table_low   <= '0;
      code_table_high  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TICK_COUNTS:     tick_counts      <= cfg_data[31:0];
        REG_GAP_MULTIPLIER:  gap_multiplier   <= cfg_data[7:0];
        REG_REPEAT_TOTAL:    repeat_total     <= cfg_data[5:0];
        REG_INVERT_LINE:     invert_line      <= cfg_data[0];
        REG_TRANSLATE:       translate_enable <= cfg_data[0];
        REG_CODE_TABLE_LOW:  code_table_low   <= cfg_data;
        REG_CODE_TABLE_HIGH: code_table_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_t'(s_axis_tuser);
  assign byte_index    = s_axis_tdata[3:0];
  assign byte_value    = s_axis_tdata[11:4];

  assign code_sel   = byte_value[3] ? code_table_high : code_table_low;
  assign write_byte = translate_enable ? code_sel[{byte_value[2:0], 3'b000} +: 8]
                                       : byte_value;

  always_ff @(posedge clk) begin
    if (in_accept && cmd == CMD_WRITE && {1'b0, byte_index} < 5'(MSG_LEN)) begin
      message_store[byte_index[IDX_W-1:0]] <= write_byte;
    end
  end

  assign store_rdata = message_store[rd_index[IDX_W-1:0]];

  assign seq_cfg.low_cnt        = tick_counts[31:24];
  assign seq_cfg.high_cnt       = tick_counts[23:16];
  assign seq_cfg.trail_cnt      = tick_counts[15:8];
  assign seq_cfg.gap_cnt        = tick_counts[7:0];
  assign seq_cfg.gap_multiplier = gap_multiplier;
  assign seq_cfg.repeat_total   = repeat_total;

  ookt_seq #(
    .MSG_LEN (MSG_LEN)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .tick_en     (in_accept && cmd == CMD_TICK),
    .start_en    (in_accept && cmd == CMD_START),
    .cfg         (seq_cfg),
    .store_rdata (store_rdata),
    .rd_index    (rd_index),
    .cur         (seq_cur),
    .nxt         (seq_nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_axis_tdata <= {6'd0, seq_nxt.active, seq_nxt.line_state ^ invert_line};
    end
  end

  a_start_sets_active: assert property (@(posedge clk) disable iff (rst)
    in_accept && cmd == CMD_START |=> seq_cur.active)
    else $error("start transaction did not make the message active");

  a_result_busy_matches: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid && m_axis_tdata[1] == seq_cur.active)
    else $error("result busy flag differs from sequencer state");

  a_idle_tick_no_change: assert property (@(posedge clk) disable iff (rst)
    in_accept && cmd == CMD_TICK && !seq_cur.active
      |=> $stable(seq_cur.line_state) && !seq_cur.active)
    else $error("tick while inactive changed the sequencer");

endmodule
